// ===== rtl/core/radar_vehicle_event_detector_defines.svh =====
// Assertion macros for the radar vehicle event detector.
// Every macro samples on the rising edge of clk and is switched off while rst_n is low.
`ifndef RADAR_VEHICLE_EVENT_DETECTOR_DEFINES_SVH
`define RADAR_VEHICLE_EVENT_DETECTOR_DEFINES_SVH

`ifndef SYNTHESIS

`define RVED_ASSERT(lbl, cond) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
        else $error("rved: check failed");

`define RVED_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("rved: implication failed");

`define RVED_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("rved: next-cycle check failed");

`else

`define RVED_ASSERT(lbl, cond)
`define RVED_ASSERT_IMP(lbl, ante, cons)
`define RVED_ASSERT_NEXT(lbl, ante, cons)

`endif

`endif

// ===== rtl/core/rved_pkg.sv =====
package rved_pkg;

    localparam int SPEED_WIDTH_DEF = 10;

    localparam int THR_W     = 10;
    localparam int FRAME_W   = 16;
    localparam int FACTOR_W  = 24;
    localparam int LEN_W     = 24;
    localparam int TIME_W    = 32;
    localparam int COUNT_W   = 32;
    localparam int MODE_W    = 2;

    localparam int CFG_INDEX_W = 3;
    localparam int CFG_DATA_W  = 24;

    // The shared multiplier is 16 by 24 bits; the full length product is 56 bits.
    localparam int MUL_A_W = 16;
    localparam int MUL_B_W = 24;
    localparam int MUL_P_W = MUL_A_W + MUL_B_W;
    localparam int SUM_W   = 56;
    localparam int ROUND_SHIFT = 16;

    localparam logic [SUM_W-1:0] ROUND_BIAS = SUM_W'(32'h0000_8000);

    localparam logic [CFG_INDEX_W-1:0] CFG_SPEED_THRESHOLD = 3'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_END_QUIET       = 3'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_MIN_DURATION    = 3'd2;
    localparam logic [CFG_INDEX_W-1:0] CFG_COOLDOWN        = 3'd3;
    localparam logic [CFG_INDEX_W-1:0] CFG_LENGTH_FACTOR   = 3'd4;
    localparam logic [CFG_INDEX_W-1:0] CFG_LONG_LENGTH     = 3'd5;

    localparam logic [THR_W-1:0]    RST_SPEED_THRESHOLD = 10'd5;
    localparam logic [FRAME_W-1:0]  RST_END_QUIET       = 16'd3;
    localparam logic [FRAME_W-1:0]  RST_MIN_DURATION    = 16'd3;
    localparam logic [FRAME_W-1:0]  RST_COOLDOWN        = 16'd5;
    localparam logic [FACTOR_W-1:0] RST_LENGTH_FACTOR   = 24'd233017;
    localparam logic [LEN_W-1:0]    RST_LONG_LENGTH     = 24'd1536;

    localparam logic [MODE_W-1:0] MODE_CODE_IDLE   = 2'd0;
    localparam logic [MODE_W-1:0] MODE_CODE_DETECT = 2'd1;
    localparam logic [MODE_W-1:0] MODE_CODE_COOL   = 2'd2;

    typedef enum logic [2:0] {
        MODE_IDLE   = 3'b001,
        MODE_DETECT = 3'b010,
        MODE_COOL   = 3'b100
    } mode_t;

    typedef enum logic [5:0] {
        SEQ_IDLE = 6'b000001,
        SEQ_PF   = 6'b000010,
        SEQ_HI   = 6'b000100,
        SEQ_LO   = 6'b001000,
        SEQ_ADD  = 6'b010000,
        SEQ_FIN  = 6'b100000
    } seq_t;

    function automatic logic [MODE_W-1:0] mode_code(input mode_t m);
        case (m)
            MODE_DETECT: return MODE_CODE_DETECT;
            MODE_COOL:   return MODE_CODE_COOL;
            default:     return MODE_CODE_IDLE;
        endcase
    endfunction

endpackage

// ===== rtl/core/rved_mul.sv =====
module rved_mul (
    input  logic                          clk,
    input  logic [rved_pkg::MUL_A_W-1:0]  a,
    input  logic [rved_pkg::MUL_B_W-1:0]  b,
    output logic [rved_pkg::MUL_P_W-1:0]  p
);
    import rved_pkg::*;

    logic [MUL_P_W-1:0] p_reg;

    // Registered product; the operands are zero-extended to the product width.
    always_ff @(posedge clk)
    begin
        p_reg <= MUL_P_W'(a) * MUL_P_W'(b);
    end

    assign p = p_reg;

endmodule

// ===== rtl/core/radar_vehicle_event_detector.sv =====
// Radar vehicle event detector. Each input item carries one radar frame: a speed in km/h and
// a millisecond timestamp. The block runs an idle / detecting / cooldown state machine, tracks
// the peak speed and length of a pass, and once a pass ends after end_quiet_frames quiet frames
// it accepts it as a vehicle if the trimmed duration reaches min_duration_frames. For every
// input item exactly one output item is produced: it flags whether this frame completed a
// vehicle and always repeats the last accepted event together with the mode after the frame.
// A frame that does not complete a vehicle goes from accept straight to the output step FIN;
// a completing frame first runs PF, HI, LO and ADD: its length peak x frames x factor
// takes three passes through a single shared 16 x 24 bit multiplier and then a rounding add.
// in_stall is high for the whole time an item is being worked on. A finished output item sits
// in the output register, so the next input item may be taken while it waits for the consumer.
// Configuration may only be written while no item is in flight.
`include "radar_vehicle_event_detector_defines.svh"

module radar_vehicle_event_detector #(
    parameter int SPEED_WIDTH = rved_pkg::SPEED_WIDTH_DEF
) (
    input  logic                               clk,
    input  logic                               rst_n,

    input  logic                               cfg_write,
    input  logic [rved_pkg::CFG_INDEX_W-1:0]   cfg_index,
    input  logic [rved_pkg::CFG_DATA_W-1:0]    cfg_data,

    input  logic                               in_valid,
    output logic                               in_stall,
    input  logic [SPEED_WIDTH-1:0]             frame_speed,
    input  logic [rved_pkg::TIME_W-1:0]        time_ms,

    output logic                               out_valid,
    input  logic                               out_stall,
    output logic                               event_valid,
    output logic [rved_pkg::COUNT_W-1:0]       vehicle_number,
    output logic [rved_pkg::TIME_W-1:0]        start_ms,
    output logic [SPEED_WIDTH-1:0]             peak_speed,
    output logic [rved_pkg::FRAME_W-1:0]       active_frames,
    output logic [rved_pkg::LEN_W-1:0]         length_q8,
    output logic                               long_vehicle,
    output logic [rved_pkg::MODE_W-1:0]        detector_mode
);
    import rved_pkg::*;

    // The threshold compare is done at the wider of the speed and threshold widths.
    localparam int CMP_W = (SPEED_WIDTH > THR_W) ? SPEED_WIDTH : THR_W;

    // Configuration registers.
    logic [THR_W-1:0]    thr_reg;
    logic [FRAME_W-1:0]  end_quiet_reg;
    logic [FRAME_W-1:0]  min_dur_reg;
    logic [FRAME_W-1:0]  cooldown_reg;
    logic [FACTOR_W-1:0] factor_reg;
    logic [LEN_W-1:0]    long_len_reg;

    // Detector state.
    mode_t               mode_reg, mode_next;
    logic [COUNT_W-1:0]  total_reg, total_next;
    logic [FRAME_W-1:0]  quiet_reg, quiet_next;
    logic [FRAME_W-1:0]  cool_reg, cool_next;
    logic [SPEED_WIDTH-1:0] cur_peak_reg, cur_peak_next;
    logic [FRAME_W-1:0]  cur_frames_reg, cur_frames_next;
    logic [TIME_W-1:0]   cur_start_reg, cur_start_next;

    // Sequencer and pending item.
    seq_t                seq_reg, seq_next;
    logic                evt_reg, evt_next;

    // Output register; the record fields hold the last accepted event.
    logic                out_valid_reg, out_valid_next;
    logic                out_event_reg, out_event_next;
    logic [MODE_W-1:0]   out_mode_reg, out_mode_next;
    logic [COUNT_W-1:0]  rec_number_reg, rec_number_next;
    logic [TIME_W-1:0]   rec_start_reg, rec_start_next;
    logic [SPEED_WIDTH-1:0] rec_peak_reg, rec_peak_next;
    logic [FRAME_W-1:0]  rec_frames_reg, rec_frames_next;
    logic [LEN_W-1:0]    rec_length_reg, rec_length_next;
    logic                rec_long_reg, rec_long_next;

    // Length datapath.
    logic [MUL_A_W-1:0]  mul_a;
    logic [MUL_B_W-1:0]  mul_b;
    logic [MUL_P_W-1:0]  mul_p;
    logic [MUL_A_W-1:0]  pf_lo_reg;
    logic [MUL_P_W-1:0]  acc_reg;
    logic [SUM_W-1:0]    sum_reg;
    logic [LEN_W-1:0]    len_sat;

    logic                in_accept;
    logic                out_free;
    logic                signal;
    logic [FRAME_W-1:0]  frames_inc;
    logic [FRAME_W-1:0]  quiet_inc;
    logic [FRAME_W-1:0]  frames_trim;
    logic [FRAME_W-1:0]  cool_inc;

    assign in_stall  = (seq_reg != SEQ_IDLE);
    assign in_accept = in_valid && !in_stall;
    assign out_free  = !out_valid_reg || !out_stall;

    // Configuration writes.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            thr_reg       <= RST_SPEED_THRESHOLD;
            end_quiet_reg <= RST_END_QUIET;
            min_dur_reg   <= RST_MIN_DURATION;
            cooldown_reg  <= RST_COOLDOWN;
            factor_reg    <= RST_LENGTH_FACTOR;
            long_len_reg  <= RST_LONG_LENGTH;
        end
        else if (cfg_write)
        begin
            case (cfg_index)
                CFG_SPEED_THRESHOLD: thr_reg       <= THR_W'(cfg_data);
                CFG_END_QUIET:       end_quiet_reg <= FRAME_W'(cfg_data);
                CFG_MIN_DURATION:    min_dur_reg   <= FRAME_W'(cfg_data);
                CFG_COOLDOWN:        cooldown_reg  <= FRAME_W'(cfg_data);
                CFG_LENGTH_FACTOR:   factor_reg    <= FACTOR_W'(cfg_data);
                CFG_LONG_LENGTH:     long_len_reg  <= LEN_W'(cfg_data);
                default:             ;
            endcase
        end
    end

    // Frame update. The whole state machine step is done in the accept cycle; only the
    // length of a completed vehicle is left to the multiply sequence.
    always_comb
    begin
        signal      = CMP_W'(frame_speed) >= CMP_W'(thr_reg);
        frames_inc  = cur_frames_reg + FRAME_W'(1);
        quiet_inc   = signal ? '0 : quiet_reg + FRAME_W'(1);
        frames_trim = frames_inc - quiet_inc;
        cool_inc    = cool_reg + FRAME_W'(1);

        mode_next       = mode_reg;
        total_next      = total_reg;
        quiet_next      = quiet_reg;
        cool_next       = cool_reg;
        cur_peak_next   = cur_peak_reg;
        cur_frames_next = cur_frames_reg;
        cur_start_next  = cur_start_reg;
        seq_next        = seq_reg;
        evt_next        = evt_reg;

        case (seq_reg)
            SEQ_IDLE:
            begin
                if (in_accept)
                begin
                    seq_next = SEQ_FIN;
                    evt_next = 1'b0;
                    case (mode_reg)
                        MODE_DETECT:
                        begin
                            cur_frames_next = frames_inc;
                            if (frame_speed > cur_peak_reg)
                            begin
                                cur_peak_next = frame_speed;
                            end
                            quiet_next = quiet_inc;
                            if (quiet_inc >= end_quiet_reg)
                            begin
                                // The pass is over: drop the quiet tail and judge it.
                                cur_frames_next = frames_trim;
                                mode_next       = MODE_COOL;
                                cool_next       = '0;
                                if (frames_trim >= min_dur_reg)
                                begin
                                    evt_next   = 1'b1;
                                    total_next = total_reg + COUNT_W'(1);
                                    seq_next   = SEQ_PF;
                                end
                            end
                        end
                        MODE_COOL:
                        begin
                            cool_next = cool_inc;
                            if (cool_inc >= cooldown_reg)
                            begin
                                mode_next = MODE_IDLE;
                            end
                        end
                        default:
                        begin
                            mode_next = MODE_IDLE;
                            if (signal)
                            begin
                                mode_next       = MODE_DETECT;
                                cur_start_next  = time_ms;
                                cur_peak_next   = frame_speed;
                                cur_frames_next = FRAME_W'(1);
                                quiet_next      = '0;
                            end
                        end
                    endcase
                end
            end
            SEQ_PF:  seq_next = SEQ_HI;
            SEQ_HI:  seq_next = SEQ_LO;
            SEQ_LO:  seq_next = SEQ_ADD;
            SEQ_ADD: seq_next = SEQ_FIN;
            SEQ_FIN:
            begin
                if (out_free)
                begin
                    seq_next = SEQ_IDLE;
                end
            end
            default: seq_next = SEQ_IDLE;
        endcase
    end

    // Operand selection for the shared multiplier. The 32-bit peak x frames product is
    // split into halves so that each half times the factor fits the 16 x 24 unit.
    always_comb
    begin
        case (seq_reg)
            SEQ_PF:
            begin
                mul_a = MUL_A_W'(cur_peak_reg);
                mul_b = MUL_B_W'(cur_frames_reg);
            end
            SEQ_HI:
            begin
                mul_a = mul_p[2*MUL_A_W-1:MUL_A_W];
                mul_b = MUL_B_W'(factor_reg);
            end
            SEQ_LO:
            begin
                mul_a = pf_lo_reg;
                mul_b = MUL_B_W'(factor_reg);
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    rved_mul u_mul (
        .clk (clk),
        .a   (mul_a),
        .b   (mul_b),
        .p   (mul_p)
    );

    always_ff @(posedge clk)
    begin
        if (seq_reg == SEQ_HI)
        begin
            pf_lo_reg <= mul_p[MUL_A_W-1:0];
        end
        if (seq_reg == SEQ_LO)
        begin
            acc_reg <= mul_p;
        end
        if (seq_reg == SEQ_ADD)
        begin
            // High partial product weighs 2^16; the bias rounds the Q24 to Q8 shift.
            sum_reg <= {acc_reg, ROUND_SHIFT'(0)} + SUM_W'(mul_p) + ROUND_BIAS;
        end
    end

    // Saturate the rounded length to 24 bits.
    assign len_sat = (|sum_reg[SUM_W-1:ROUND_SHIFT+LEN_W]) ? '1
                                                           : sum_reg[ROUND_SHIFT+LEN_W-1:ROUND_SHIFT];

    // Output register. The record only changes when a new output item is loaded, so it
    // holds still while the consumer stalls.
    always_comb
    begin
        out_valid_next  = out_valid_reg && out_stall;
        out_event_next  = out_event_reg;
        out_mode_next   = out_mode_reg;
        rec_number_next = rec_number_reg;
        rec_start_next  = rec_start_reg;
        rec_peak_next   = rec_peak_reg;
        rec_frames_next = rec_frames_reg;
        rec_length_next = rec_length_reg;
        rec_long_next   = rec_long_reg;

        if (seq_reg == SEQ_FIN && out_free)
        begin
            out_valid_next = 1'b1;
            out_event_next = evt_reg;
            out_mode_next  = mode_code(mode_reg);
            if (evt_reg)
            begin
                rec_number_next = total_reg;
                rec_start_next  = cur_start_reg;
                rec_peak_next   = cur_peak_reg;
                rec_frames_next = cur_frames_reg;
                rec_length_next = len_sat;
                rec_long_next   = (len_sat >= long_len_reg);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg       <= MODE_IDLE;
            total_reg      <= '0;
            quiet_reg      <= '0;
            cool_reg       <= '0;
            cur_peak_reg   <= '0;
            cur_frames_reg <= '0;
            cur_start_reg  <= '0;
            seq_reg        <= SEQ_IDLE;
            evt_reg        <= 1'b0;
            out_valid_reg  <= 1'b0;
            out_event_reg  <= 1'b0;
            out_mode_reg   <= MODE_CODE_IDLE;
            rec_number_reg <= '0;
            rec_start_reg  <= '0;
            rec_peak_reg   <= '0;
            rec_frames_reg <= '0;
            rec_length_reg <= '0;
            rec_long_reg   <= 1'b0;
        end
        else
        begin
            mode_reg       <= mode_next;
            total_reg      <= total_next;
            quiet_reg      <= quiet_next;
            cool_reg       <= cool_next;
            cur_peak_reg   <= cur_peak_next;
            cur_frames_reg <= cur_frames_next;
            cur_start_reg  <= cur_start_next;
            seq_reg        <= seq_next;
            evt_reg        <= evt_next;
            out_valid_reg  <= out_valid_next;
            out_event_reg  <= out_event_next;
            out_mode_reg   <= out_mode_next;
            rec_number_reg <= rec_number_next;
            rec_start_reg  <= rec_start_next;
            rec_peak_reg   <= rec_peak_next;
            rec_frames_reg <= rec_frames_next;
            rec_length_reg <= rec_length_next;
            rec_long_reg   <= rec_long_next;
        end
    end

    assign out_valid      = out_valid_reg;
    assign event_valid    = out_event_reg;
    assign vehicle_number = rec_number_reg;
    assign start_ms       = rec_start_reg;
    assign peak_speed     = rec_peak_reg;
    assign active_frames  = rec_frames_reg;
    assign length_q8      = rec_length_reg;
    assign long_vehicle   = rec_long_reg;
    assign detector_mode  = out_mode_reg;

    // A completed vehicle always leaves the detector in cooldown.
    `RVED_ASSERT_IMP(a_event_in_cooldown, out_valid && event_valid, detector_mode == MODE_CODE_COOL)
    // The multiply sequence only runs for a pass that has just ended.
    `RVED_ASSERT_IMP(a_mul_after_pass, seq_reg == SEQ_PF || seq_reg == SEQ_HI || seq_reg == SEQ_LO || seq_reg == SEQ_ADD, mode_reg == MODE_COOL && evt_reg)
    // Only one item is in flight at a time.
    `RVED_ASSERT_NEXT(a_single_item, in_valid && !in_stall, in_stall)
    // A new output item is loaded only when the previous one has gone or is going.
    `RVED_ASSERT_IMP(a_no_overwrite, seq_reg == SEQ_FIN && out_valid_reg && out_stall, seq_next == SEQ_FIN)

endmodule
